// File: hw/rtl/integer_square_root_unit_assert.svh
// assertion macros shared by the square root datapath files
// no dependencies; the macros expand to nothing when SYNTHESIS is defined
`ifndef INTEGER_SQUARE_ROOT_UNIT_ASSERT_SVH
`define INTEGER_SQUARE_ROOT_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

// condition must hold at every edge out of reset
`define ISQRT_ASSERT_ALWAYS(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// consequent in the same cycle
`define ISQRT_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// consequent in the next cycle
`define ISQRT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define ISQRT_ASSERT_ALWAYS(label, clk, rst, expr, msg)
`define ISQRT_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg)
`define ISQRT_ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

// File: hw/rtl/isqrt_pkg.sv
// widths and the per-stage record of the pipelined square root
// no dependencies
package isqrt_pkg;

   localparam int RADICAND_W = 64;
   localparam int ROOT_W     = 32;
   // partial remainder never exceeds twice the partial root
   localparam int REM_W      = ROOT_W + 1;
   // remainder shifted by one digit pair, compared against the trial value
   localparam int CMP_W      = REM_W + 2;

   typedef struct packed {
      logic [RADICAND_W-1:0] radicand;
      logic [REM_W-1:0]      rem;
      logic [ROOT_W-1:0]     root;
   } stage_type;

endpackage

// File: hw/rtl/isqrt_channels.sv
// valid/ready channel interfaces for square root requests and responses
// depends on isqrt_pkg
interface isqrt_req_if;
   import isqrt_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [RADICAND_W-1:0] radicand;

   modport source (output valid, output radicand, input ready);
   modport sink   (input valid, input radicand, output ready);
endinterface

interface isqrt_rsp_if;
   import isqrt_pkg::*;

   logic              valid;
   logic              ready;
   logic [ROOT_W-1:0] root;

   modport source (output valid, output root, input ready);
   modport sink   (input valid, input root, output ready);
endinterface

// File: hw/rtl/integer_square_root_unit.sv
// Integer square root: root = floor(sqrt(radicand)) for an unsigned radicand,
// exact for every input; radicand bits above RADICAND_BITS are ignored.
// One pipeline stage per root bit, (RADICAND_BITS+1)/2 stages (32 for the
// default 64-bit radicand), each a 35-bit compare and subtract. A transaction
// accepted by the unit passes through the stage registers in order before it
// shows up on rsp_chan, and a new request can be taken every cycle while the
// pipeline is not held. While a finished response waits on rsp_chan.ready,
// the whole pipeline holds and no request is accepted.
// Depends on isqrt_pkg, isqrt_channels, isqrt_stage and the assertion header.
`include "integer_square_root_unit_assert.svh"

module integer_square_root_unit #(
   parameter int RADICAND_BITS = 64
) (
   input logic         clock,
   input logic         reset,
   isqrt_req_if.sink   req_chan,
   isqrt_rsp_if.source rsp_chan
);
   import isqrt_pkg::*;

   localparam int ROOT_STEPS  = (RADICAND_BITS + 1) / 2;
   localparam int ALIGN_SHIFT = RADICAND_W - 2 * ROOT_STEPS;
   localparam logic [RADICAND_W-1:0] RADICAND_MASK =
      {RADICAND_W{1'b1}} >> (RADICAND_W - RADICAND_BITS);

   logic      advance;
   logic      stage_valid [0:ROOT_STEPS];
   stage_type stage_data  [0:ROOT_STEPS];

   // whole pipeline moves when the response slot is empty or being taken
   assign advance = !stage_valid[ROOT_STEPS] || rsp_chan.ready;

   assign req_chan.ready = advance;

   // top digit pair of the used width lands in the two top bits
   assign stage_valid[0]         = req_chan.valid;
   assign stage_data[0].radicand = (req_chan.radicand & RADICAND_MASK) << ALIGN_SHIFT;
   assign stage_data[0].rem      = '0;
   assign stage_data[0].root     = '0;

   for (genvar s = 0; s < ROOT_STEPS; s++) begin : g_step
      isqrt_stage u_stage (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .in_valid  (stage_valid[s]),
         .in_data   (stage_data[s]),
         .out_valid (stage_valid[s+1]),
         .out_data  (stage_data[s+1])
      );
   end

   assign rsp_chan.valid = stage_valid[ROOT_STEPS];
   assign rsp_chan.root  = stage_data[ROOT_STEPS].root;

   `ISQRT_ASSERT_NEXT(a_accept_enters, clock, reset, req_chan.valid && req_chan.ready,
      stage_valid[1], "accepted transaction missing from first stage")

   `ISQRT_ASSERT_NEXT(a_stall_holds, clock, reset, stage_valid[ROOT_STEPS] && !advance,
      stage_valid[ROOT_STEPS] && $stable(stage_data[ROOT_STEPS].root),
      "pending response changed during stall")

   `ISQRT_ASSERT_IMPLIES(a_root_range, clock, reset, rsp_chan.valid,
      (rsp_chan.root >> ROOT_STEPS) == '0, "root wider than radicand allows")

endmodule

// File: hw/rtl/isqrt_stage.sv
// one restoring square root step: settles one root bit from the top digit pair
// depends on isqrt_pkg and integer_square_root_unit_assert.svh
`include "integer_square_root_unit_assert.svh"

module isqrt_stage (
   input  logic                clock,
   input  logic                reset,
   input  logic                advance,
   input  logic                in_valid,
   input  isqrt_pkg::stage_type in_data,
   output logic                out_valid,
   output isqrt_pkg::stage_type out_data
);
   import isqrt_pkg::*;

   logic [CMP_W-1:0] partial;
   logic [CMP_W-1:0] trial;
   logic [CMP_W-1:0] diff;
   logic             fits;

   logic      valid_ff;
   logic      valid_in;
   stage_type data_ff;
   stage_type data_in;

   always_comb begin
      partial = {in_data.rem, in_data.radicand[RADICAND_W-1 -: 2]};
      trial   = {1'b0, in_data.root, 2'b01};
      diff    = partial - trial;
      fits    = (partial >= trial);

      // next digit pair moves to the top
      data_in.radicand = in_data.radicand << 2;
      if (fits) begin
         data_in.rem  = diff[REM_W-1:0];
         data_in.root = {in_data.root[ROOT_W-2:0], 1'b1};
      end else begin
         data_in.rem  = partial[REM_W-1:0];
         data_in.root = {in_data.root[ROOT_W-2:0], 1'b0};
      end
   end

   assign valid_in = advance ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   // restoring invariant: remainder stays within twice the partial root
   `ISQRT_ASSERT_IMPLIES(a_rem_bound, clock, reset, valid_ff, data_ff.rem <= (REM_W'(data_ff.root) << 1), "partial remainder exceeds bound")

   `ISQRT_ASSERT_NEXT(a_stall_keeps_valid, clock, reset, !advance, $stable(valid_ff), "stage valid changed during stall")

   `ISQRT_ASSERT_NEXT(a_advance_loads_valid, clock, reset, advance, valid_ff == $past(in_valid), "stage valid did not follow its input")

endmodule

// File: tb/sv/integer_square_root_unit_tb.sv
// self-checking testbench for integer_square_root_unit: floor square root of a radicand
// depends on isqrt_pkg, the isqrt_req_if/isqrt_rsp_if channel interfaces and the unit itself
module integer_square_root_unit_tb;
   import isqrt_pkg::*;

   localparam int RADICAND_BITS = 64;
   localparam int ROOT_STEPS    = (RADICAND_BITS + 1) / 2;
   localparam int DRAIN_CYCLES  = ROOT_STEPS + 8;
   localparam int CYCLE_LIMIT   = 200000;
   localparam int RANDOM_PER_PHASE = 150;

   typedef enum int {
      SLOW_RECEIVER,
      SLOW_SENDER,
      NO_IDLING
   } idle_mode_type;

   // holds the roots still owed by the unit, in order of acceptance
   class root_scoreboard;
      logic [ROOT_W-1:0] pending_roots[$];
      int unsigned       mismatches;

      function new();
         mismatches = 0;
      endfunction

      // restoring digit-by-digit square root, one root bit per digit pair
      function logic [ROOT_W-1:0] floor_sqrt(input logic [RADICAND_W-1:0] radicand);
         logic [RADICAND_W-1:0] masked;
         logic [63:0]           partial;
         logic [63:0]           trial;
         logic [63:0]           root;
         masked  = (RADICAND_BITS >= 64) ? radicand
                 : radicand & ((64'd1 << RADICAND_BITS) - 64'd1);
         partial = 64'd0;
         root    = 64'd0;
         for (int step = ROOT_STEPS - 1; step >= 0; step--) begin
            partial = (partial << 2) | ((masked >> (2 * step)) & 64'd3);
            trial   = (root << 2) | 64'd1;
            if (partial >= trial) begin
               partial = partial - trial;
               root    = (root << 1) | 64'd1;
            end else begin
               root = root << 1;
            end
         end
         return root[ROOT_W-1:0];
      endfunction

      function void note_radicand(input logic [RADICAND_W-1:0] radicand);
         pending_roots.push_back(floor_sqrt(radicand));
      endfunction

      function void check_root(input logic [ROOT_W-1:0] root);
         logic [ROOT_W-1:0] expected;
         if (pending_roots.size() == 0) begin
            $display("%0t: unexpected root transaction, actual %h", $time, root);
            mismatches++;
         end else begin
            expected = pending_roots.pop_front();
            if (root !== expected) begin
               $display("%0t: root mismatch, expected %h actual %h", $time, expected, root);
               mismatches++;
            end
         end
      endfunction

      function int unsigned outstanding();
         return pending_roots.size();
      endfunction
   endclass

   logic clock;
   logic reset;
   idle_mode_type idle_mode;
   longint unsigned cycle_count;

   isqrt_req_if req_bus();
   isqrt_rsp_if rsp_bus();

   root_scoreboard scoreboard = new();

   integer_square_root_unit #(
      .RADICAND_BITS(RADICAND_BITS)
   ) u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic int unsigned sender_idle_pct();
      case (idle_mode)
         SLOW_RECEIVER: return 14;
         SLOW_SENDER:   return 85;
         default:       return 0;
      endcase
   endfunction

   function automatic int unsigned receiver_idle_pct();
      case (idle_mode)
         SLOW_RECEIVER: return 85;
         SLOW_SENDER:   return 14;
         default:       return 0;
      endcase
   endfunction

   task automatic send_radicand(input logic [RADICAND_W-1:0] value);
      int unsigned gap;
      gap = 0;
      while ($urandom_range(99) < sender_idle_pct()) gap++;
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid    <= 1'b1;
      req_bus.radicand <= value;
      do @(posedge clock); while (!req_bus.ready);
      scoreboard.note_radicand(value);
   endtask

   // hold off until the unit has returned everything it owes
   task automatic wait_for_drain();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (scoreboard.outstanding() != 0);
   endtask

   function automatic logic [RADICAND_W-1:0] random_radicand();
      logic [63:0] root;
      logic [63:0] value;
      case ($urandom_range(9))
         0, 1, 2, 3: value = {$urandom, $urandom};
         4, 5, 6:    value = {$urandom, $urandom} >> $urandom_range(63, 0);
         default: begin
            // perfect squares and their neighbors
            root  = 64'({$urandom} >> $urandom_range(31, 0));
            value = root * root;
            case ($urandom_range(2))
               0:       value = value - 64'd1;
               1:       value = value + 64'd1;
               default: ;
            endcase
         end
      endcase
      return value;
   endfunction

   task automatic send_directed();
      logic [RADICAND_W-1:0] corner[$];
      corner = '{64'd0, 64'd1, 64'd2, 64'd3, 64'd4, 64'd8, 64'd9, 64'd15, 64'd16, 64'd17,
                 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFE,
                 64'hFFFF_FFFE_0000_0001, 64'hFFFF_FFFE_0000_0000,
                 64'h8000_0000_0000_0000, 64'h4000_0000_0000_0000,
                 64'h3FFF_FFFF_FFFF_FFFF, 64'h0000_0001_0000_0000,
                 64'h0000_0000_FFFF_FFFF, 64'hAAAA_AAAA_AAAA_AAAA,
                 64'h5555_5555_5555_5555};
      foreach (corner[i]) send_radicand(corner[i]);
   endtask

   // response side: check each accepted transaction, then pick the next ready
   initial begin
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_bus.valid && rsp_bus.ready) scoreboard.check_root(rsp_bus.root);
         rsp_bus.ready <= ($urandom_range(99) >= receiver_idle_pct());
      end
   end

   initial begin
      cycle_count = 0;
      forever begin
         @(posedge clock);
         cycle_count++;
         if (cycle_count > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
         end
      end
   end

   initial begin
      idle_mode        = SLOW_RECEIVER;
      reset            <= 1'b1;
      req_bus.valid    <= 1'b0;
      req_bus.radicand <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_directed();
      wait_for_drain();

      for (int mode = SLOW_RECEIVER; mode <= NO_IDLING; mode++) begin
         idle_mode = idle_mode_type'(mode);
         for (int n = 0; n < RANDOM_PER_PHASE; n++) send_radicand(random_radicand());
         wait_for_drain();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (scoreboard.mismatches == 0 && scoreboard.outstanding() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
